/* rtl/lsa_pkg.sv */
package lsa_pkg;

  localparam int unsigned OFS_W = 17;
  localparam int unsigned CALC_W = 19;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_REWIND = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_DONE         = 3'd0,
    ST_UPSTREAM     = 3'd1,
    ST_OUT_OF_MEM   = 3'd2,
    ST_FREE_IGNORED = 3'd3,
    ST_BAD_MARKER   = 3'd4
  } status_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_FALLBACK = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic             valid;
    logic [OFS_W-1:0] prev_ofs;
    logic [OFS_W-1:0] end_ofs;
  } header_t;

  localparam int unsigned HEADER_W = $bits(header_t);

endpackage

/* rtl/lsa_ram.sv */
module lsa_ram #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lifo_stack_allocator.sv */
// Stack allocator with per-block headers over one buffer. Offsets are byte offsets from the
// buffer start. After reset the header RAM, BUFFER_BYTES / HEADER_ALIGN entries (8192 with
// the defaults), is swept clear, one entry per cycle; no item is taken in that time, while
// configuration writes are taken at any time. Allocate, rewind, query and a free whose
// offset fails the range or alignment checks load their result directly; any other free
// first passes through a read state, since the header is read from the synchronous RAM
// before the top is updated. Results sit in an output register, and a new item is taken in
// the cycle the previous result is transferred or once the register is empty.
module lifo_stack_allocator #(
  parameter int unsigned BUFFER_BYTES = 65536,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned HEADER_ALIGN = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [16:0] request_bytes,
  input  logic [3:0]  align_log2,
  input  logic [31:0] free_offset,
  input  logic [16:0] marker_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [16:0] block_offset,
  output logic [16:0] used_bytes
);

  localparam int unsigned DEPTH = BUFFER_BYTES / HEADER_ALIGN;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned ALIGN_LOG2 = $clog2(HEADER_ALIGN);
  localparam int unsigned OFS_W = lsa_pkg::OFS_W;
  localparam int unsigned CALC_W = lsa_pkg::CALC_W;
  localparam logic [OFS_W-1:0] BUF_LIM =
    (BUFFER_BYTES > (2**OFS_W - 1)) ? OFS_W'(2**OFS_W - 1) : OFS_W'(BUFFER_BYTES);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   clr_idx;
  logic [OFS_W-1:0]   top;
  logic [OFS_W-1:0]   capacity;
  logic               fallback;

  logic [OFS_W-1:0]   cap_eff;
  logic               accept;
  logic               out_free;
  logic               res_load;
  lsa_pkg::action_t   act;
  logic [3:0]         lg_eff;
  logic [CALC_W-1:0]  mask;
  logic [CALC_W-1:0]  base;
  logic [CALC_W-1:0]  user;
  logic [CALC_W-1:0]  end_calc;
  logic               fits;
  logic               alloc_in_range;
  logic               free_bad;
  logic [IDX_W-1:0]   alloc_idx;
  logic [IDX_W-1:0]   free_idx;

  lsa_pkg::status_t   res_status;
  logic [OFS_W-1:0]   res_block;
  logic [OFS_W-1:0]   top_next;

  logic                         we;
  logic [IDX_W-1:0]             waddr;
  logic [lsa_pkg::HEADER_W-1:0] wdata;
  logic [lsa_pkg::HEADER_W-1:0] rdata;
  lsa_pkg::header_t             entry;
  logic                         free_ok;

  assign cfg_ready = 1'b1;
  assign cap_eff = (capacity > BUF_LIM) ? BUF_LIM : capacity;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept = in_valid && in_ready;
  assign act = lsa_pkg::action_t'(action);
  assign res_load = (state == S_READ) ||
                    (accept && !(act == lsa_pkg::ACT_FREE && !free_bad));

  assign lg_eff = (align_log2 > 4'(ALIGN_LOG2)) ? align_log2 : 4'(ALIGN_LOG2);
  assign mask = (CALC_W'(1) << lg_eff) - CALC_W'(1);
  assign base = CALC_W'(top) + CALC_W'(HEADER_BYTES);
  assign user = (base + mask) & ~mask;
  assign end_calc = user + CALC_W'(request_bytes);
  assign fits = end_calc <= CALC_W'(cap_eff);
  assign alloc_in_range = 32'(user) < 32'(BUFFER_BYTES);
  assign alloc_idx = IDX_W'(user >> ALIGN_LOG2);

  assign free_bad = (free_offset >= 32'(cap_eff)) || (free_offset < 32'(HEADER_BYTES)) ||
                    (free_offset[ALIGN_LOG2-1:0] != '0);
  assign free_idx = IDX_W'(free_offset >> ALIGN_LOG2);

  assign entry = lsa_pkg::header_t'(rdata);
  assign free_ok = entry.valid && (entry.end_ofs == top) && (entry.prev_ofs <= top);

  always_comb begin
    res_status = lsa_pkg::ST_DONE;
    res_block = '0;
    top_next = top;
    unique case (act)
      lsa_pkg::ACT_ALLOC: begin
        if (fits) begin
          res_block = OFS_W'(user);
          top_next = OFS_W'(end_calc);
        end else begin
          res_status = fallback ? lsa_pkg::ST_UPSTREAM : lsa_pkg::ST_OUT_OF_MEM;
        end
      end
      lsa_pkg::ACT_FREE: begin
        res_status = lsa_pkg::ST_FREE_IGNORED;
      end
      lsa_pkg::ACT_REWIND: begin
        if (marker_offset > top) begin
          res_status = lsa_pkg::ST_BAD_MARKER;
        end else begin
          top_next = marker_offset;
        end
      end
      lsa_pkg::ACT_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = alloc_idx;
    wdata = lsa_pkg::HEADER_W'({1'b1, top, OFS_W'(end_calc)});
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_idx;
      wdata = '0;
    end else if (accept && act == lsa_pkg::ACT_ALLOC && fits && alloc_in_range) begin
      we = 1'b1;
    end
  end

  lsa_ram #(
    .WIDTH(lsa_pkg::HEADER_W),
    .DEPTH(DEPTH)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(free_idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      top <= '0;
      capacity <= OFS_W'(65536);
      fallback <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (lsa_pkg::reg_index_t'(cfg_index))
          lsa_pkg::REG_CAPACITY: capacity <= cfg_data;
          lsa_pkg::REG_FALLBACK: fallback <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == IDX_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (act == lsa_pkg::ACT_FREE && !free_bad) begin
              state <= S_READ;
            end else begin
              top <= top_next;
              status <= res_status;
              block_offset <= res_block;
              used_bytes <= top_next;
            end
          end
        end
        S_READ: begin
          status <= free_ok ? lsa_pkg::ST_DONE : lsa_pkg::ST_FREE_IGNORED;
          block_offset <= '0;
          if (free_ok) begin
            top <= entry.prev_ofs;
            used_bytes <= entry.prev_ofs;
          end else begin
            used_bytes <= top;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/lsa_checker.sv */
module lsa_checker #(
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned HEADER_ALIGN = 8
) (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [16:0] block_offset,
  input logic [16:0] used_bytes
);

  localparam int unsigned ALIGN_LOG2 = $clog2(HEADER_ALIGN);

  // A stalled result keeps its payload until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(block_offset) &&
    $stable(used_bytes))
    else $error("Stalled result changed before its transfer.");

  // A new item is only taken when the output register can hold its result.
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || out_ready)
    else $error("Input taken while the output register is blocked.");

  // Only a successful allocate reports a block offset.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lsa_pkg::ST_DONE |-> block_offset == '0)
    else $error("Block offset reported without a successful allocate.");

  // An allocated block is aligned, leaves room for its header and starts at or below the top.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == lsa_pkg::ST_DONE && block_offset != '0 |->
    block_offset[ALIGN_LOG2-1:0] == '0 && 32'(block_offset) >= 32'(HEADER_BYTES) &&
    used_bytes >= block_offset)
    else $error("Allocated block is misplaced.");

endmodule

bind lifo_stack_allocator lsa_checker #(
  .HEADER_BYTES(HEADER_BYTES),
  .HEADER_ALIGN(HEADER_ALIGN)
) u_lsa_checker (.*);
